// ----- rtl/ttr_pkg.sv -----
// ----------------------------------------------------------------------------
// ttr_pkg
// Field widths and stream item layouts of the triangle tile rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ttr_pkg;

  localparam int unsigned VERT_W     = 16;
  localparam int unsigned TILE_IDX_W = 8;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned PIX_W      = 11;
  localparam int unsigned MASK_W     = 8;

  localparam int unsigned S_DATA_W = 6 * VERT_W + 2 * TILE_IDX_W + COLOR_W;
  localparam int unsigned M_PAD_W  = 2;
  localparam int unsigned M_DATA_W = 2 * PIX_W + MASK_W + COLOR_W + M_PAD_W;
  localparam int unsigned M_USER_W = 1;

  // listed from the top bit down
  typedef struct packed {
    logic        [COLOR_W-1:0]    fill_color;
    logic        [TILE_IDX_W-1:0] tile_row;
    logic        [TILE_IDX_W-1:0] tile_col;
    logic signed [VERT_W-1:0]     vert_c_y;
    logic signed [VERT_W-1:0]     vert_c_x;
    logic signed [VERT_W-1:0]     vert_b_y;
    logic signed [VERT_W-1:0]     vert_b_x;
    logic signed [VERT_W-1:0]     vert_a_y;
    logic signed [VERT_W-1:0]     vert_a_x;
  } in_item_t;

  typedef struct packed {
    logic [M_PAD_W-1:0] pad;
    logic [COLOR_W-1:0] color_out;
    logic [MASK_W-1:0]  coverage_mask;
    logic [PIX_W-1:0]   pixel_col_base;
    logic [PIX_W-1:0]   pixel_row;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/triangle_tile_rasterizer_core.sv -----
// ----------------------------------------------------------------------------
// triangle_tile_rasterizer_core
// Edge-function coverage of one triangle over one tile, one mask row a cycle while not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one triangle/tile transaction: three Q12.4 vertices, the
//   tile column and row, and the fill color. m_axis returns TILE_SIZE
//   transactions per triangle, top row first: pixel row, column base,
//   coverage mask and color in tdata, the degenerate flag in tuser, and
//   tlast on the final row of the tile.
//   A triangle passes the input register, the setup stage and the row engine
//   into the output register. The engine produces one mask row per cycle
//   from incrementally stepped edge values while the output is not stalled.
//   A setup stage (edge products) and an input register run ahead of the
//   engine, so the next triangles are taken while rows are still going out.
//   Reset clears all valid flags; no transaction is in flight afterwards.
//   When m_axis_tready_i is low, the output register holds its row, the
//   engine stops, and s_axis_tready_o drops once the front stages fill.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_tile_rasterizer_core #(
  parameter int TILE_SIZE = 8,
  parameter int IMAGE_DIM = 2048,
  parameter int FRAC_BITS = 4
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y,
  // tile_col, tile_row, fill_color
  input  wire  [ttr_pkg::S_DATA_W-1:0]   s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  wire                            m_axis_tready_i,
  // pixel_row, pixel_col_base, coverage_mask, color_out, 2 bits zero
  output logic [ttr_pkg::M_DATA_W-1:0]   m_axis_tdata_o,
  // degenerate
  output logic [ttr_pkg::M_USER_W-1:0]   m_axis_tuser_o,
  // last_row
  output logic                           m_axis_tlast_o
);

  localparam int VW      = ttr_pkg::VERT_W;
  localparam int DW      = VW + 2;
  localparam int BW      = VW + 2;
  localparam int AW      = 2 * DW + 1;
  localparam int C0W     = $clog2(256 * TILE_SIZE);
  localparam int PW      = $clog2(2 * 256 * TILE_SIZE * (1 << FRAC_BITS));
  localparam int OW      = ((PW > VW + 1) ? PW : VW + 1) + 2;
  localparam int PRW     = DW + OW;
  localparam int EW      = PRW + 1;
  localparam int RCW     = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
  localparam int MW      = (TILE_SIZE < ttr_pkg::MASK_W) ? TILE_SIZE : ttr_pkg::MASK_W;
  localparam int HALF    = (1 << FRAC_BITS) >> 1;
  localparam int STEP_SH = FRAC_BITS + 1;

  function automatic logic signed [VW-1:0] min3_f(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b,
                                                  input logic signed [VW-1:0] c);
    logic signed [VW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [VW-1:0] max3_f(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b,
                                                  input logic signed [VW-1:0] c);
    logic signed [VW-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // (v + 0.5) cut to a whole pixel, -1 below zero
  function automatic logic signed [BW-1:0] bound_f(input logic signed [VW-1:0] v);
    logic signed [VW:0] t;
    t = (VW + 1)'(v) + (VW + 1)'(HALF);
    if (t < 0) begin
      return '1;
    end
    return BW'(t >>> FRAC_BITS);
  endfunction

  // ---------------- handshake ----------------
  logic a_valid_q, b_valid_q, c_busy_q, out_valid_q;
  logic a_adv, c_load, out_load, c_last, s_acc;

  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign a_adv           = a_valid_q && (!b_valid_q || c_load);
  assign s_axis_tready_o = !a_valid_q || a_adv;
  assign out_load        = c_busy_q && (!out_valid_q || m_axis_tready_i);
  assign c_load          = b_valid_q && (!c_busy_q || (c_last && out_load));

  // ---------------- input register ----------------
  ttr_pkg::in_item_t a_q;

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      a_q <= ttr_pkg::in_item_t'(s_axis_tdata_i);
    end
  end

  // ---------------- setup: deltas, origin offsets, products ----------------
  logic signed [DW-1:0]  ax2, ay2, bx2, by2, cx2, cy2;
  logic signed [DW-1:0]  dx_d [3];
  logic signed [DW-1:0]  dy_d [3];
  logic        [C0W-1:0] col0_d, row0_d;
  logic signed [OW-1:0]  px0, py0;
  logic signed [OW-1:0]  ox_d [3];
  logic signed [OW-1:0]  oy_d [3];

  always_comb begin
    ax2 = DW'(a_q.vert_a_x) <<< 1;
    ay2 = DW'(a_q.vert_a_y) <<< 1;
    bx2 = DW'(a_q.vert_b_x) <<< 1;
    by2 = DW'(a_q.vert_b_y) <<< 1;
    cx2 = DW'(a_q.vert_c_x) <<< 1;
    cy2 = DW'(a_q.vert_c_y) <<< 1;
    // edges B->C, C->A, A->B
    dx_d[0] = cx2 - bx2;
    dy_d[0] = cy2 - by2;
    dx_d[1] = ax2 - cx2;
    dy_d[1] = ay2 - cy2;
    dx_d[2] = bx2 - ax2;
    dy_d[2] = by2 - ay2;
    col0_d = C0W'(a_q.tile_col) * C0W'(TILE_SIZE);
    row0_d = C0W'(a_q.tile_row) * C0W'(TILE_SIZE);
    px0 = OW'({col0_d, 1'b1}) << FRAC_BITS;
    py0 = OW'({row0_d, 1'b1}) << FRAC_BITS;
    ox_d[0] = px0 - OW'(bx2);
    oy_d[0] = py0 - OW'(by2);
    ox_d[1] = px0 - OW'(cx2);
    oy_d[1] = py0 - OW'(cy2);
    ox_d[2] = px0 - OW'(ax2);
    oy_d[2] = py0 - OW'(ay2);
  end

  logic signed [2*DW-1:0]             b_pa1_q, b_pa2_q;
  logic signed [PRW-1:0]              b_pl_q [3];
  logic signed [PRW-1:0]              b_pr_q [3];
  logic signed [DW-1:0]               b_dx_q [3];
  logic signed [DW-1:0]               b_dy_q [3];
  logic signed [BW-1:0]               b_minx_q, b_maxx_q, b_miny_q, b_maxy_q;
  logic        [C0W-1:0]              b_col0_q, b_row0_q;
  logic        [ttr_pkg::COLOR_W-1:0] b_color_q;

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_pa1_q <= dy_d[2] * (-dx_d[1]);
      b_pa2_q <= dx_d[2] * (-dy_d[1]);
      for (int j = 0; j < 3; j++) begin
        b_pl_q[j] <= dx_d[j] * oy_d[j];
        b_pr_q[j] <= dy_d[j] * ox_d[j];
        b_dx_q[j] <= dx_d[j];
        b_dy_q[j] <= dy_d[j];
      end
      b_minx_q  <= bound_f(min3_f(a_q.vert_a_x, a_q.vert_b_x, a_q.vert_c_x));
      b_maxx_q  <= bound_f(max3_f(a_q.vert_a_x, a_q.vert_b_x, a_q.vert_c_x));
      b_miny_q  <= bound_f(min3_f(a_q.vert_a_y, a_q.vert_b_y, a_q.vert_c_y));
      b_maxy_q  <= bound_f(max3_f(a_q.vert_a_y, a_q.vert_b_y, a_q.vert_c_y));
      b_col0_q  <= col0_d;
      b_row0_q  <= row0_d;
      b_color_q <= a_q.fill_color;
    end
  end

  // ---------------- engine load: area sign, normalized edges ----------------
  logic signed [AW-1:0] area;
  logic                 ld_neg, ld_degen;
  logic signed [EW-1:0] ld_e  [3];
  logic signed [EW-1:0] ld_sx [3];
  logic signed [EW-1:0] ld_sy [3];

  always_comb begin
    area     = AW'(b_pa2_q) - AW'(b_pa1_q);
    ld_neg   = area[AW-1];
    ld_degen = (area == '0);
    for (int j = 0; j < 3; j++) begin
      ld_e[j]  = EW'(b_pl_q[j]) - EW'(b_pr_q[j]);
      ld_sy[j] = EW'(b_dx_q[j]) <<< STEP_SH;
      ld_sx[j] = -(EW'(b_dy_q[j]) <<< STEP_SH);
      if (ld_neg) begin
        ld_e[j]  = -ld_e[j];
        ld_sy[j] = -ld_sy[j];
        ld_sx[j] = -ld_sx[j];
      end
    end
  end

  // ---------------- row engine ----------------
  logic        [RCW-1:0]              c_cnt_q;
  logic signed [EW-1:0]               c_e_q  [3];
  logic signed [EW-1:0]               c_sx_q [3];
  logic signed [EW-1:0]               c_sy_q [3];
  logic signed [BW-1:0]               c_minx_q, c_maxx_q, c_miny_q, c_maxy_q;
  logic        [C0W-1:0]              c_col0_q, c_row0_q;
  logic        [ttr_pkg::COLOR_W-1:0] c_color_q;
  logic                               c_degen_q;

  assign c_last = (c_cnt_q == RCW'(TILE_SIZE - 1));

  always_ff @(posedge clk_i) begin
    if (c_load) begin
      for (int j = 0; j < 3; j++) begin
        c_e_q[j]  <= ld_e[j];
        c_sx_q[j] <= ld_sx[j];
        c_sy_q[j] <= ld_sy[j];
      end
      c_minx_q  <= b_minx_q;
      c_maxx_q  <= b_maxx_q;
      c_miny_q  <= b_miny_q;
      c_maxy_q  <= b_maxy_q;
      c_col0_q  <= b_col0_q;
      c_row0_q  <= b_row0_q;
      c_color_q <= b_color_q;
      c_degen_q <= ld_degen;
    end else if (out_load) begin
      for (int j = 0; j < 3; j++) begin
        c_e_q[j] <= c_e_q[j] + c_sy_q[j];
      end
    end
  end

  logic [C0W-1:0]              row_y;
  logic [ttr_pkg::MASK_W-1:0]  mask_d;

  always_comb begin
    logic signed [BW-1:0] ys;
    logic signed [BW-1:0] xs;
    logic        [C0W-1:0] xv;
    logic signed [EW-1:0] ev;
    logic                 row_ok;
    logic                 hit;
    row_y  = c_row0_q + C0W'(c_cnt_q);
    ys     = BW'(row_y);
    row_ok = !c_degen_q && (ys >= c_miny_q) && (ys < c_maxy_q) && (32'(row_y) < IMAGE_DIM);
    mask_d = '0;
    for (int k = 0; k < MW; k++) begin
      xv  = c_col0_q + C0W'(k);
      xs  = BW'(xv);
      hit = row_ok && (xs >= c_minx_q) && (xs < c_maxx_q) && (32'(xv) < IMAGE_DIM);
      for (int j = 0; j < 3; j++) begin
        ev  = c_e_q[j] + c_sx_q[j] * EW'(k);
        hit = hit && !ev[EW-1];
      end
      mask_d[k] = hit;
    end
  end

  // ---------------- output register ----------------
  ttr_pkg::out_item_t o_item_q;
  logic               o_degen_q, o_last_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_item_q.pad            <= '0;
      o_item_q.color_out      <= c_color_q;
      o_item_q.coverage_mask  <= mask_d;
      o_item_q.pixel_col_base <= ttr_pkg::PIX_W'(c_col0_q);
      o_item_q.pixel_row      <= ttr_pkg::PIX_W'(row_y);
      o_degen_q               <= c_degen_q;
      o_last_q                <= c_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = o_item_q;
  assign m_axis_tuser_o  = o_degen_q;
  assign m_axis_tlast_o  = o_last_q;

  // ---------------- control state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_busy_q    <= 1'b0;
      c_cnt_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_acc) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
      if (a_adv) begin
        b_valid_q <= 1'b1;
      end else if (c_load) begin
        b_valid_q <= 1'b0;
      end
      if (c_load) begin
        c_busy_q <= 1'b1;
        c_cnt_q  <= '0;
      end else if (out_load) begin
        c_cnt_q <= c_cnt_q + RCW'(1);
        if (c_last) begin
          c_busy_q <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ttr_checker.sv -----
// ----------------------------------------------------------------------------
// ttr_checker
// Port-level checks of the rasterizer output stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ttr_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          m_axis_tvalid_o,
  input wire                          m_axis_tready_i,
  input wire [ttr_pkg::M_DATA_W-1:0]  m_axis_tdata_o,
  input wire [ttr_pkg::M_USER_W-1:0]  m_axis_tuser_o,
  input wire                          m_axis_tlast_o
);

  ttr_pkg::out_item_t m_item;
  assign m_item = ttr_pkg::out_item_t'(m_axis_tdata_o);

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("stalled output transaction changed");

  a_degen_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_item.coverage_mask == '0)
    else $error("degenerate triangle with nonzero mask");

  // rows of one tile follow back to back, one row further each
  a_row_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      m_axis_tvalid_o
      && m_item.pixel_row == $past(m_item.pixel_row) + 11'd1
      && m_item.pixel_col_base == $past(m_item.pixel_col_base))
    else $error("tile row sequence broken");

endmodule

bind triangle_tile_rasterizer_core ttr_checker u_ttr_checker (.*);

`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for triangle_tile_rasterizer_core.
// Triangle/tile transactions go in on s_axis. An internal edge-function
// predictor expands each accepted triangle into its eight expected mask
// rows. Every m_axis row is checked field by field against the oldest
// expected row. The sender and the receiver stall at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int      TILE      = 8;
  localparam int      IMAGE_DIM = 2048;
  localparam int      FRAC_BITS = 4;
  localparam longint  ONE_FIX   = 64'sd1 << FRAC_BITS;
  localparam longint  HALF_FIX  = ONE_FIX / 2;
  localparam int      CYCLE_LIMIT = 400000;
  localparam int      TAIL_CYCLES = 20;

  typedef struct packed {
    ttr_pkg::out_item_t data;
    logic               degenerate;
    logic               last_row;
  } mask_row_t;

  class coverage_scoreboard;
    mask_row_t rows_due[$];
    int        mismatches;

    function longint edge_val(longint ux, longint uy, longint vx, longint vy,
                              longint px, longint py);
      return (vx - ux) * (py - uy) - (vy - uy) * (px - ux);
    endfunction

    // (v + 0.5) truncated to a whole pixel, anything negative below all tiles
    function longint pix_bound(longint v);
      longint t;
      t = v + HALF_FIX;
      return (t < 0) ? -1 : (t >>> FRAC_BITS);
    endfunction

    function longint lo3(longint a, longint b, longint c);
      longint m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
    endfunction

    function longint hi3(longint a, longint b, longint c);
      longint m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
    endfunction

    function void note_triangle(ttr_pkg::in_item_t t);
      longint    ax, ay, bx, by, cx, cy;
      longint    area, sgn, min_x, max_x, min_y, max_y;
      longint    col0, row0, x, y, px, py, e0, e1, e2;
      logic      degen;
      mask_row_t r_exp;
      ax = $signed(t.vert_a_x);
      ay = $signed(t.vert_a_y);
      bx = $signed(t.vert_b_x);
      by = $signed(t.vert_b_y);
      cx = $signed(t.vert_c_x);
      cy = $signed(t.vert_c_y);
      min_x = pix_bound(lo3(ax, bx, cx));
      max_x = pix_bound(hi3(ax, bx, cx));
      min_y = pix_bound(lo3(ay, by, cy));
      max_y = pix_bound(hi3(ay, by, cy));
      // doubled coordinates keep the pixel centers exact
      ax = 2 * ax; ay = 2 * ay;
      bx = 2 * bx; by = 2 * by;
      cx = 2 * cx; cy = 2 * cy;
      area  = edge_val(ax, ay, bx, by, cx, cy);
      degen = (area == 0);
      sgn   = (area < 0) ? -1 : 1;
      col0  = longint'(t.tile_col) * TILE;
      row0  = longint'(t.tile_row) * TILE;
      for (int r = 0; r < TILE; r++) begin
        y = row0 + r;
        r_exp = '0;
        if (!degen && y >= min_y && y < max_y && y < IMAGE_DIM) begin
          py = (2 * y + 1) * ONE_FIX;
          for (int k = 0; k < TILE; k++) begin
            x = col0 + k;
            if (x >= min_x && x < max_x && x < IMAGE_DIM && k < ttr_pkg::MASK_W) begin
              px = (2 * x + 1) * ONE_FIX;
              e0 = edge_val(bx, by, cx, cy, px, py) * sgn;
              e1 = edge_val(cx, cy, ax, ay, px, py) * sgn;
              e2 = edge_val(ax, ay, bx, by, px, py) * sgn;
              if (e0 >= 0 && e1 >= 0 && e2 >= 0) r_exp.data.coverage_mask[k] = 1'b1;
            end
          end
        end
        r_exp.data.pixel_row      = y[ttr_pkg::PIX_W-1:0];
        r_exp.data.pixel_col_base = col0[ttr_pkg::PIX_W-1:0];
        r_exp.data.color_out      = t.fill_color;
        r_exp.degenerate          = degen;
        r_exp.last_row            = (r == TILE - 1);
        rows_due.push_back(r_exp);
      end
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_row(ttr_pkg::out_item_t got, logic got_degen, logic got_last);
      mask_row_t r_exp;
      if (rows_due.size() == 0) begin
        $display("%0t: row transaction with nothing expected, actual %h", $time, got);
        mismatches++;
        return;
      end
      r_exp = rows_due.pop_front();
      compare("pixel_row", r_exp.data.pixel_row, got.pixel_row);
      compare("pixel_col_base", r_exp.data.pixel_col_base, got.pixel_col_base);
      compare("coverage_mask", r_exp.data.coverage_mask, got.coverage_mask);
      compare("color_out", r_exp.data.color_out, got.color_out);
      compare("pad", r_exp.data.pad, got.pad);
      compare("degenerate", r_exp.degenerate, got_degen);
      compare("last_row", r_exp.last_row, got_last);
    endfunction

    function int pending();
      return rows_due.size();
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid_i = 1'b0;
  logic                         s_axis_tready_o;
  logic [ttr_pkg::S_DATA_W-1:0] s_axis_tdata_i = '0;
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i = 1'b0;
  logic [ttr_pkg::M_DATA_W-1:0] m_axis_tdata_o;
  logic [ttr_pkg::M_USER_W-1:0] m_axis_tuser_o;
  logic                         m_axis_tlast_o;

  coverage_scoreboard sb;
  int                 tx_idle_pct = 0;
  int                 rx_idle_pct = 0;
  int                 cycle_count = 0;

  triangle_tile_rasterizer_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        sb.note_triangle(ttr_pkg::in_item_t'(s_axis_tdata_i));
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_row(ttr_pkg::out_item_t'(m_axis_tdata_o), m_axis_tuser_o[0],
                     m_axis_tlast_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int clamp16(int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic ttr_pkg::in_item_t tri_item(int ax, int ay, int bx, int by,
                                                 int cx, int cy,
                                                 int col, int row, int color);
    ttr_pkg::in_item_t it;
    it.vert_a_x   = 16'(ax);
    it.vert_a_y   = 16'(ay);
    it.vert_b_x   = 16'(bx);
    it.vert_b_y   = 16'(by);
    it.vert_c_x   = 16'(cx);
    it.vert_c_y   = 16'(cy);
    it.tile_col   = 8'(col);
    it.tile_row   = 8'(row);
    it.fill_color = 24'(color);
    return it;
  endfunction

  // mostly triangles that overlap the chosen tile, plus slivers, colinear
  // sets and fully random vertices
  function automatic ttr_pkg::in_item_t random_triangle();
    int vx[3], vy[3];
    int col, row, ox, oy, dx, dy, kind;
    col  = $urandom_range(0, 255);
    row  = $urandom_range(0, 255);
    kind = $urandom_range(0, 99);
    ox   = col * TILE * 16;
    oy   = row * TILE * 16;
    if (kind < 12) begin
      for (int i = 0; i < 3; i++) begin
        vx[i] = int'($urandom_range(0, 65535)) - 32768;
        vy[i] = int'($urandom_range(0, 65535)) - 32768;
      end
    end else if (kind < 24) begin
      vx[0] = ox + int'($urandom_range(0, 256)) - 64;
      vy[0] = oy + int'($urandom_range(0, 256)) - 64;
      dx = int'($urandom_range(0, 96)) - 48;
      dy = int'($urandom_range(0, 96)) - 48;
      vx[1] = vx[0] + dx;      vy[1] = vy[0] + dy;
      vx[2] = vx[0] - 2 * dx;  vy[2] = vy[0] - 2 * dy;
    end else if (kind < 36) begin
      ox = ox + int'($urandom_range(0, 128)) - 16;
      oy = oy + int'($urandom_range(0, 128)) - 16;
      for (int i = 0; i < 3; i++) begin
        vx[i] = ox + int'($urandom_range(0, 40));
        vy[i] = oy + int'($urandom_range(0, 40));
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        vx[i] = ox - 96 + int'($urandom_range(0, 320));
        vy[i] = oy - 96 + int'($urandom_range(0, 320));
      end
    end
    return tri_item(clamp16(vx[0]), clamp16(vy[0]), clamp16(vx[1]), clamp16(vy[1]),
                    clamp16(vx[2]), clamp16(vy[2]), col, row, $urandom_range(0, 24'hFFFFFF));
  endfunction

  task automatic send_triangle(ttr_pkg::in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= it;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_triangle(random_triangle());
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 26;
    rx_idle_pct = 80;
    // large cover of tile 0, both windings
    send_triangle(tri_item(-160, -160, 1600, -160, -160, 1600, 0, 0, 0));
    send_triangle(tri_item(-160, -160, -160, 1600, 1600, -160, 0, 0, 24'hFFFFFF));
    // colinear and coincident vertices
    send_triangle(tri_item(0, 0, 16, 16, 32, 32, 0, 0, 24'h123456));
    send_triangle(tri_item(32767, 32767, 32767, 32767, 32767, 32767, 255, 255, 24'hABCDEF));
    send_triangle(tri_item(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 24'h000001));
    // vertex extremes
    send_triangle(tri_item(-32768, -32768, 32767, -32768, -32768, 32767, 255, 255, 24'h800000));
    send_triangle(tri_item(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0, 24'h7FFFFF));
    send_triangle(tri_item(32767, 32767, -32768, 32767, 32767, -32768, 255, 255, 24'h5A5A5A));
    send_triangle(tri_item(32767, -32768, 32767, 32767, -32768, 32767, 255, 0, 24'hA5A5A5));
    // edges running through pixel centers
    send_triangle(tri_item(8, 8, 120, 8, 8, 120, 0, 0, 24'h00FF00));
    send_triangle(tri_item(8, 8, 8, 120, 120, 8, 0, 0, 24'h0000FF));
    send_triangle(tri_item(120, 8, 120, 120, 8, 120, 0, 0, 24'hFF0000));
    // box maximum exactly on a pixel boundary
    send_triangle(tri_item(8, 8, 56, 8, 8, 56, 0, 0, 24'h111111));
    // box entirely negative, and crossing zero
    send_triangle(tri_item(-500, -500, -100, -500, -500, -100, 0, 0, 24'h222222));
    send_triangle(tri_item(-40, -40, 100, -40, -40, 100, 0, 0, 24'h333333));
    // thin sliver, nonzero area
    send_triangle(tri_item(0, 0, 128, 1, 0, 2, 0, 0, 24'h444444));
    // tiles away from the origin, alternating index bits
    send_triangle(tri_item(2700, 1300, 2800, 1400, 2700, 1500, 170, 85, 24'h555555));
    send_triangle(tri_item(1400, 2800, 1300, 2700, 1500, 2700, 85, 170, 24'h666666));
    send_triangle(tri_item(600, 400, 700, 500, 560, 520, 5, 3, 24'h777777));
    send_random(75);
    drain();

    tx_idle_pct = 80;
    rx_idle_pct = 26;
    send_random(75);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(70);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ttr_pkg.sv
rtl/triangle_tile_rasterizer_core.sv
rtl/ttr_checker.sv
bench/testbench.sv
